@@ design/connected_components_dfs_top_defines.svh @@
// Shared assertion macros for the connected components block.
`ifndef CONNECTED_COMPONENTS_DFS_TOP_DEFINES_SVH
`define CONNECTED_COMPONENTS_DFS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccd assertion failed");

// Next-cycle implication, disabled during reset.
`define CCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccd assertion failed");

`endif

@@ design/ccd_pkg.sv @@
`default_nettype none
package ccd_pkg;

  localparam int unsigned VertexWidth = 6;
  localparam int unsigned RowWidth    = 64;
  localparam int unsigned CountWidth  = 7;

  typedef struct packed {
    logic init;
    logic root_next;
    logic emit_root;
    logic rd_top;
    logic load_row;
    logic rd_j;
    logic j_next;
    logic push;
    logic pop;
    logic pop_load;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_seen;
    logic scan_done;
    logic hit;
    logic depth_one;
    logic can_emit;
  } status_t;

endpackage
`default_nettype wire

@@ design/connected_components_dfs_top.sv @@
// Connected components by depth-first search. Rows of the adjacency matrix
// arrive one per cycle and are stored when row_index < node_count (clamped to
// MAX_NODES); an edge counts only if both rows mark it. The row with last_row
// starts the search, during which no input is taken. Every vertex in use comes
// out once in preorder with its group, last_in_group and last. The search
// reads one stored row per step: S_SCAN and S_CHK per candidate neighbour,
// S_LOAD and S_LOADW per root or push, S_POP per pop (then S_POPW and a load
// unless the stack empties) and S_ROOT per root index, plus output stalls.
`default_nettype none
module connected_components_dfs_top #(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            node_count_we,
  input  wire logic [ccd_pkg::CountWidth-1:0]  node_count,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ccd_pkg::VertexWidth-1:0] row_index,
  input  wire logic [ccd_pkg::RowWidth-1:0]    neighbour_bits,
  input  wire logic                            last_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ccd_pkg::VertexWidth-1:0]      vertex,
  output logic [ccd_pkg::VertexWidth-1:0]      group,
  output logic                                 last_in_group,
  output logic                                 last
);

  ccd_pkg::cmd_t    cmd;
  ccd_pkg::status_t sts;

  ccd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_row (last_row),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccd_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .node_count_we  (node_count_we),
    .node_count     (node_count),
    .in_accept      (in_valid && in_ready),
    .row_index      (row_index),
    .neighbour_bits (neighbour_bits),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vertex         (vertex),
    .group          (group),
    .last_in_group  (last_in_group),
    .last           (last)
  );

endmodule
`default_nettype wire

@@ design/ccd_ctrl.sv @@
`default_nettype none
module ccd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            last_row,
  output logic                 in_ready,
  input  wire ccd_pkg::status_t sts,
  output ccd_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_LOADW = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_POPW  = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_row) begin
          cmd.init   = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        priority if (sts.root_done) begin
          state_next = S_FLUSH;
        end else if (sts.root_seen) begin
          cmd.root_next = 1'b1;
        end else if (sts.can_emit) begin
          cmd.emit_root = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.rd_top = 1'b1;
        state_next = S_LOADW;
      end
      S_LOADW: begin
        cmd.load_row = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_POP;
        end else begin
          cmd.rd_j   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.hit) begin
          if (sts.can_emit) begin
            cmd.push   = 1'b1;
            state_next = S_LOAD;
          end
        end else begin
          cmd.j_next = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = sts.depth_one ? S_ROOT : S_POPW;
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        state_next   = S_LOAD;
      end
      S_FLUSH: begin
        if (sts.can_emit) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ design/ccd_dp.sv @@
`default_nettype none
`include "connected_components_dfs_top_defines.svh"
module ccd_dp #(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                node_count_we,
  input  wire logic [ccd_pkg::CountWidth-1:0]      node_count,
  input  wire logic                                in_accept,
  input  wire logic [ccd_pkg::VertexWidth-1:0]     row_index,
  input  wire logic [ccd_pkg::RowWidth-1:0]        neighbour_bits,
  input  wire ccd_pkg::cmd_t                       cmd,
  output ccd_pkg::status_t                         sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ccd_pkg::VertexWidth-1:0]          vertex,
  output logic [ccd_pkg::VertexWidth-1:0]          group,
  output logic                                     last_in_group,
  output logic                                     last
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned SW = AW + CW;
  localparam logic [ccd_pkg::CountWidth-1:0] MaxCount = ccd_pkg::CountWidth'(MAX_NODES);

  logic [ccd_pkg::CountWidth-1:0] node_cfg;
  logic [ccd_pkg::CountWidth-1:0] n_sat;
  logic [CW-1:0]                  n_use;

  logic [ccd_pkg::RowWidth-1:0] adj_mem [MAX_NODES];
  logic [ccd_pkg::RowWidth-1:0] adj_rdata;
  logic [ccd_pkg::RowWidth-1:0] cur_row;
  logic [SW-1:0]                stk_mem [MAX_NODES];
  logic [SW-1:0]                stk_rdata;

  logic [MAX_NODES-1:0]         visited;
  logic [CW-1:0]                root;
  logic [CW-1:0]                j;
  logic [CW-1:0]                depth;
  logic [AW-1:0]                top_v;
  logic [CW-1:0]                top_next;
  logic [ccd_pkg::VertexWidth-1:0] group_counter;

  logic                         pend_valid;
  logic [AW-1:0]                pend_v;
  logic [ccd_pkg::VertexWidth-1:0] pend_g;

  logic                         out_free;
  logic                         emit;
  logic [AW-1:0]                emit_v;
  logic                         row_wr;

  assign n_sat    = (node_cfg > MaxCount) ? MaxCount : node_cfg;
  assign n_use    = n_sat[CW-1:0];
  assign row_wr   = in_accept && ({1'b0, row_index} < n_sat);
  assign out_free = !out_valid || out_ready;
  assign emit     = cmd.emit_root || cmd.push;
  assign emit_v   = cmd.emit_root ? root[AW-1:0] : j[AW-1:0];

  assign sts.root_done = (root >= n_use);
  assign sts.root_seen = visited[root[AW-1:0]];
  assign sts.scan_done = (j >= n_use);
  assign sts.hit       = cur_row[j[AW-1:0]] && adj_rdata[top_v] && !visited[j[AW-1:0]];
  assign sts.depth_one = (depth == CW'(1));
  assign sts.can_emit  = !pend_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_cfg <= ccd_pkg::CountWidth'(36);
    end else if (node_count_we) begin
      node_cfg <= node_count;
    end
  end

  // Row storage: written on input transactions with row_index in range, read for top row and candidates.
  always_ff @(posedge clk) begin
    if (row_wr) begin
      adj_mem[row_index[AW-1:0]] <= neighbour_bits;
    end
    if (cmd.rd_top) begin
      adj_rdata <= adj_mem[top_v];
    end else if (cmd.rd_j) begin
      adj_rdata <= adj_mem[j[AW-1:0]];
    end
  end

  // Walk stack holds entries below the top; the top lives in top_v/top_next.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[AW'(depth - CW'(1))] <= {CW'(j + CW'(1)), top_v};
    end
    if (cmd.pop && !sts.depth_one) begin
      stk_rdata <= stk_mem[AW'(depth - CW'(2))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      cur_row <= adj_rdata;
    end
    if (cmd.emit_root) begin
      top_v    <= root[AW-1:0];
      top_next <= '0;
    end else if (cmd.push) begin
      top_v    <= j[AW-1:0];
      top_next <= '0;
    end else if (cmd.pop_load) begin
      top_v    <= stk_rdata[AW-1:0];
      top_next <= stk_rdata[SW-1:AW];
    end
    if (cmd.load_row) begin
      j <= top_next;
    end else if (cmd.j_next) begin
      j <= j + CW'(1);
    end
    if (emit) begin
      pend_v <= emit_v;
      pend_g <= group_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited       <= '0;
      root          <= '0;
      depth         <= '0;
      group_counter <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (cmd.init) begin
        visited       <= '0;
        root          <= '0;
        depth         <= '0;
        group_counter <= '0;
        pend_valid    <= 1'b0;
      end else begin
        if (cmd.root_next) begin
          root <= root + CW'(1);
        end
        if (emit) begin
          visited[emit_v] <= 1'b1;
          pend_valid      <= 1'b1;
        end
        if (cmd.flush) begin
          pend_valid <= 1'b0;
        end
        if (cmd.emit_root) begin
          depth <= CW'(1);
        end else if (cmd.push) begin
          depth <= depth + CW'(1);
        end else if (cmd.pop) begin
          depth <= depth - CW'(1);
          if (sts.depth_one) begin
            group_counter <= group_counter + 1'b1;
            root          <= root + CW'(1);
          end
        end
      end
    end
  end

  // A held vertex is released once the next emission or the end shows its flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((emit || cmd.flush) && pend_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit || cmd.flush) && pend_valid) begin
      vertex        <= ccd_pkg::VertexWidth'(pend_v);
      group         <= pend_g;
      last_in_group <= cmd.emit_root || cmd.flush;
      last          <= cmd.flush;
    end
  end

  `CCD_ASSERT_IMP(a_depth_bound, 1'b1, depth <= n_use)
  `CCD_ASSERT_IMP(a_emit_room, emit && pend_valid, out_free)
  `CCD_ASSERT_NXT(a_flush_clears, cmd.flush, !pend_valid)
  `CCD_ASSERT_IMP(a_push_fresh, cmd.push, !visited[j[AW-1:0]] && (j < n_use))

endmodule
`default_nettype wire
